// ----- src/insertion_sorter_assert.svh -----
// Assertion macros used by the insertion sorter module.
`ifndef INSERTION_SORTER_ASSERT_SVH
`define INSERTION_SORTER_ASSERT_SVH

// Property checked on every rising edge outside reset.
`define INS_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("insertion sorter check failed");

// Property checked on every rising edge, reset included.
`define INS_ASSERT_ALWAYS(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("insertion sorter check failed");

`endif

// ----- src/ins_sort_pkg.sv -----
// Package with the item types and cell control type of the insertion sorter.
`default_nettype none

package ins_sort_pkg;

  localparam int VALUE_W = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef struct packed {
    value_t in_value;
    logic   in_last;
  } in_item_t;

  typedef struct packed {
    value_t out_value;
    logic   out_last;
    logic   overflow;
  } out_item_t;

  typedef struct packed {
    logic ins;
    logic shift;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- src/ins_sort_cell.sv -----
// One cell of the insertion chain: holds a value and its occupied bit.
`default_nettype none

module ins_sort_cell
  import ins_sort_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire cell_ctrl_t ctrl,
  input  wire value_t     new_value,
  input  wire value_t     left_value,
  input  wire logic       left_occ,
  input  wire logic       left_gt,
  input  wire value_t     right_value,
  input  wire logic       right_occ,
  output value_t          value,
  output logic            occ,
  output logic            gt
);

  logic take_new;

  assign gt       = occ && (value > new_value);
  assign take_new = gt || (!occ && left_occ);

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else if (ctrl.ins) begin
      if (left_gt || take_new) begin
        occ <= 1'b1;
      end
    end else if (ctrl.shift) begin
      occ <= right_occ;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (left_gt) begin
        value <= left_value;
      end else if (take_new) begin
        value <= new_value;
      end
    end else if (ctrl.shift) begin
      value <= right_value;
    end
  end

endmodule

`default_nettype wire

// ----- src/insertion_sorter.sv -----
// Insertion sorter: a systolic chain of cells that sorts a set and drains it in order.
// Collecting: one item per cycle; every cell compares and shifts in the same cycle.
// Drain: the first result is offered the cycle after the closing item is accepted,
// then one result per cycle while result_stall is low.
// Items are stalled during the drain. Reset clears the occupied bits of all cells,
// the overflow flag and the drain state; no clearing pass is needed.
`default_nettype none

module insertion_sorter
  import ins_sort_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire in_item_t  item,
  output logic           result_valid,
  input  wire logic      result_stall,
  output out_item_t      result
);

  `include "insertion_sorter_assert.svh"

  value_t           vals [DEPTH];
  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] gts;
  cell_ctrl_t       ctrl;
  logic             draining;
  logic             dropped;
  logic             item_take;
  logic             result_take;

  assign item_stall   = draining;
  assign item_take    = item_valid && !item_stall;
  assign result_valid = draining && occ[0];
  assign result_take  = result_valid && !result_stall;

  assign ctrl.ins   = item_take && !occ[DEPTH-1];
  assign ctrl.shift = result_take;

  assign result.out_value = vals[0];
  assign result.out_last  = !occ[1];
  assign result.overflow  = dropped;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    value_t lv;
    logic   lo;
    logic   lg;
    value_t rv;
    logic   ro;

    if (i == 0) begin : g_first
      assign lv = item.in_value;
      assign lo = 1'b1;
      assign lg = 1'b0;
    end else begin : g_inner_l
      assign lv = vals[i-1];
      assign lo = occ[i-1];
      assign lg = gts[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign rv = vals[i];
      assign ro = 1'b0;
    end else begin : g_inner_r
      assign rv = vals[i+1];
      assign ro = occ[i+1];
    end

    ins_sort_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .new_value   (item.in_value),
      .left_value  (lv),
      .left_occ    (lo),
      .left_gt     (lg),
      .right_value (rv),
      .right_occ   (ro),
      .value       (vals[i]),
      .occ         (occ[i]),
      .gt          (gts[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (result_take && result.out_last) begin
      draining <= 1'b0;
      dropped  <= 1'b0;
    end else if (item_take) begin
      if (occ[DEPTH-1]) begin
        dropped <= 1'b1;
      end
      if (item.in_last) begin
        draining <= 1'b1;
      end
    end
  end

  `INS_ASSERT(a_occ_contiguous, ((occ & (occ + DEPTH'(1))) == '0))
  `INS_ASSERT(a_close_offers_result, (item_take && item.in_last) |=> result_valid)
  `INS_ASSERT(a_drain_empties, (result_take && result.out_last) |=> (!draining && (occ == '0)))
  `INS_ASSERT_ALWAYS(a_reset_idle, rst |=> (!draining && !dropped))

endmodule

`default_nettype wire
